// ----- rtl/fmo_pkg.sv -----
// Shared types, register indexes and the quarter-wave sine table generator.
package fmo_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;
  localparam int STEP_BITS      = 24;
  localparam int DEPTH_BITS     = 18;
  localparam int AMP_BITS       = 16;
  localparam int SINE_MAG_BITS  = 15;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CARRIER_STEP   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODULATOR_STEP = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MOD_DEPTH      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_COUNT   = 3'd4;

  localparam logic [AMP_BITS-1:0] AMP_RESET = 16'd32768;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned FULL_Q15    = 64'd32767;

  typedef struct packed {
    logic accept;
    logic mod_read;
    logic mod_mul;
    logic car_read;
    logic car_mul;
    logic emit;
  } fmo_cmd_t;

  typedef struct packed {
    logic run;
  } fmo_sts_t;

  // One table entry: round(32767 * sin(pi/2 * i / 2^tbits)) by a Taylor series in Q2.30.
  function automatic logic [SINE_MAG_BITS-1:0] sine_entry(input int unsigned i,
                                                          input int unsigned tbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned val;
    longint          sum;
    x    = (HALF_PI_Q30 * 64'(i)) >> tbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      case (k)
        1: term = ((term * x2) >> 30) / 64'd6;
        2: term = ((term * x2) >> 30) / 64'd20;
        3: term = ((term * x2) >> 30) / 64'd42;
        4: term = ((term * x2) >> 30) / 64'd72;
        5: term = ((term * x2) >> 30) / 64'd110;
        default: term = ((term * x2) >> 30) / 64'd156;
      endcase
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    val = (longint'(sum) * FULL_Q15 + (64'd1 << 29)) >> 30;
    if (val > FULL_Q15) begin
      val = FULL_Q15;
    end
    return val[SINE_MAG_BITS-1:0];
  endfunction

endpackage

// ----- rtl/fmo_ctrl.sv -----
// Sequencing state machine for one sample: two table reads, two products, one output beat.
module fmo_ctrl
  import fmo_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  fmo_sts_t sts,
  output fmo_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_OFS  = 3'd2;
  localparam logic [2:0] S_CAR  = 3'd3;
  localparam logic [2:0] S_AMP  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && sts.run) begin
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_read = 1'b1;
        state_next   = S_OFS;
      end
      S_OFS: begin
        cmd.mod_mul = 1'b1;
        state_next  = S_CAR;
      end
      S_CAR: begin
        cmd.car_read = 1'b1;
        state_next   = S_AMP;
      end
      S_AMP: begin
        cmd.car_mul = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- rtl/fmo_dp.sv -----
// Datapath: settings, phase accumulators, sine table, shared multiplier and output register.
module fmo_dp
  import fmo_pkg::*;
#(
  parameter int PHASE_BITS      = 24,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16,
  parameter int COUNT_BITS      = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      restart,
  input  fmo_cmd_t                  cmd,
  output fmo_sts_t                  sts,
  output logic [SAMPLE_BITS-1:0]    sample,
  output logic                      last
);

  localparam int TAB_N     = 1 << SINE_TABLE_BITS;
  localparam int ADDR_BITS = SINE_TABLE_BITS + 1;
  localparam int PROD_BITS = DEPTH_BITS + 1 + SINE_MAG_BITS + 1;
  localparam int SH        = 31 - SAMPLE_BITS;
  localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [STEP_BITS-1:0]  carrier_step;
  logic [STEP_BITS-1:0]  modulator_step;
  logic [DEPTH_BITS-1:0] mod_depth;
  logic [AMP_BITS-1:0]   amplitude;
  logic [COUNT_BITS-1:0] sample_count;

  logic [PHASE_BITS-1:0] carrier_phase;
  logic [PHASE_BITS-1:0] modulator_phase;
  logic [COUNT_BITS-1:0] sample_index;

  logic [SINE_MAG_BITS-1:0] rom_word [0:TAB_N];
  logic [SINE_MAG_BITS-1:0] rom_q;
  logic [ADDR_BITS-1:0]     rom_addr;
  logic                     neg_q;

  logic [31:0] mod_wide;
  logic [31:0] car_wide;
  logic [31:0] total;
  logic [31:0] look_phase;
  logic [SINE_TABLE_BITS-1:0] look_idx;

  logic signed [SINE_MAG_BITS:0]   sin_val;
  logic signed [DEPTH_BITS:0]      op_a;
  logic signed [PROD_BITS-1:0]     prod;

  logic                 prod_neg;
  logic [PROD_BITS-1:0] prod_mag;
  logic [PROD_BITS-1:0] rnd;
  logic [SAMPLE_BITS-1:0] sat;

  for (genvar i = 0; i <= TAB_N; i++) begin : g_rom
    localparam logic [SINE_MAG_BITS-1:0] ENTRY = sine_entry(i, SINE_TABLE_BITS);
    assign rom_word[i] = ENTRY;
  end

  assign sts.run = restart ? (sample_count != '0) : (sample_index < sample_count);

  assign mod_wide   = 32'(modulator_phase) << (32 - PHASE_BITS);
  assign car_wide   = 32'(carrier_phase) << (32 - PHASE_BITS);
  assign total      = car_wide + {prod[30:0], 1'b0};
  assign look_phase = cmd.mod_read ? mod_wide : total;
  assign look_idx   = look_phase[29 -: SINE_TABLE_BITS];
  assign rom_addr   = look_phase[30] ? (ADDR_BITS'(TAB_N) - {1'b0, look_idx})
                                     : {1'b0, look_idx};

  assign sin_val = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
  assign op_a    = cmd.car_mul ? $signed((DEPTH_BITS+1)'(amplitude))
                               : $signed({1'b0, mod_depth});

  assign prod_neg = prod[PROD_BITS-1];
  assign prod_mag = prod_neg ? PROD_BITS'(-prod) : PROD_BITS'(prod);
  assign rnd      = (prod_mag + (PROD_BITS'(1) << (SH - 1))) >> SH;

  always_comb begin
    if (!prod_neg) begin
      sat = (rnd > PROD_BITS'(S_MAX)) ? S_MAX : rnd[SAMPLE_BITS-1:0];
    end else begin
      sat = (rnd > PROD_BITS'(S_MIN)) ? S_MIN : -rnd[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rom_q <= rom_word[rom_addr];
    if (cmd.mod_read || cmd.car_read) begin
      neg_q <= look_phase[31];
    end
    if (cmd.mod_mul || cmd.car_mul) begin
      prod <= op_a * sin_val;
    end
    if (cmd.emit) begin
      sample <= sat;
      last   <= ((COUNT_BITS+1)'(sample_index) + (COUNT_BITS+1)'(1)) == {1'b0, sample_count};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_step    <= '0;
      modulator_step  <= '0;
      mod_depth       <= '0;
      amplitude       <= AMP_RESET;
      sample_count    <= '0;
      carrier_phase   <= '0;
      modulator_phase <= '0;
      sample_index    <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_CARRIER_STEP:   carrier_step   <= cfg_data;
          REG_MODULATOR_STEP: modulator_step <= cfg_data;
          REG_MOD_DEPTH:      mod_depth      <= cfg_data[DEPTH_BITS-1:0];
          REG_AMPLITUDE:      amplitude      <= cfg_data[AMP_BITS-1:0];
          REG_SAMPLE_COUNT:   sample_count   <= COUNT_BITS'(cfg_data);
          default: begin
          end
        endcase
      end
      if (cmd.accept && restart) begin
        carrier_phase   <= '0;
        modulator_phase <= '0;
        sample_index    <= '0;
      end else if (cmd.emit) begin
        carrier_phase   <= carrier_phase + PHASE_BITS'(carrier_step);
        modulator_phase <= modulator_phase + PHASE_BITS'(modulator_step);
        sample_index    <= sample_index + COUNT_BITS'(1);
      end
    end
  end

endmodule

// ----- rtl/fm_synthesis_oscillator.sv -----
// Two-operator FM tone generator: top level joining the sequencer and the datapath.
//
// Settings are written on the cfg channel (cfg_valid, cfg_index, cfg_data); cfg_ready is
// always high and a write takes effect at that edge. Index 0 is the carrier step, 1 the
// modulator step, 2 the modulation depth, 3 the amplitude and 4 the tone length.
// Write them only while no tick is in progress.
// Each input beat (in_valid, in_stall, restart) is one sample tick. A tick inside the tone
// produces one output beat (out_valid, out_stall, sample, last); a tick past the end of the
// tone produces nothing and does not raise in_stall.
// A producing tick steps through acceptance, two reads of the shared sine table, each followed
// by a product on the one shared multiplier, and the output cycle, which can wait on a stall.
// The result is registered when the output cycle emits it, after both reads and products.
// in_stall is high while a tick is in progress. When the receiver stalls, the result stays
// in the output register; a new tick may still be accepted and runs up to its output cycle,
// where it waits for the register to drain.
// Reset clears both phases and the sample counter, sets the amplitude to full scale and
// every other setting to zero, so no samples appear until a tone length is written.
module fm_synthesis_oscillator
  import fmo_pkg::*;
#(
  parameter int PHASE_BITS      = 24,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16,
  parameter int COUNT_BITS      = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      restart,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [SAMPLE_BITS-1:0]    sample,
  output logic                      last
);

  fmo_cmd_t cmd;
  fmo_sts_t sts;

  assign cfg_ready = 1'b1;

  fmo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fmo_dp #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .restart   (restart),
    .cmd       (cmd),
    .sts       (sts),
    .sample    (sample),
    .last      (last)
  );

endmodule
